// ===== hw/rtl/archive_directory_record_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the directory record parser
// Shared helpers that keep concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_DIRECTORY_RECORD_PARSER_ASSERT_SVH
`define ARCHIVE_DIRECTORY_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define ADRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define ADRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/adrp_pkg.sv =====
// ----------------------------------------------------------------------------
// adrp_pkg
// Types and constants shared by the directory record parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package adrp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEFT_W = 9;

  localparam int unsigned HEADER_BYTES_DEF = 10;

  // Record flag codes that select the tail layout
  localparam logic [BYTE_W-1:0] FLAG_LEN16 = 8'h2B;
  localparam logic [BYTE_W-1:0] FLAG_FIX20 = 8'h33;
  localparam logic [BYTE_W-1:0] FLAG_FIX40 = 8'h39;
  localparam logic [BYTE_W-1:0] FLAG_LEN20 = 8'h3B;

  localparam logic [LEFT_W-1:0] WORD_BYTES  = 9'd12;
  localparam logic [LEFT_W-1:0] OFFSET_DONE = 9'd8;
  localparam logic [LEFT_W-1:0] PACKED_DONE = 9'd4;
  localparam logic [LEFT_W-1:0] TAIL_EXTRA16 = 9'd16;
  localparam logic [LEFT_W-1:0] TAIL_EXTRA20 = 9'd20;
  localparam logic [LEFT_W-1:0] TAIL_FIX20 = 9'd20;
  localparam logic [LEFT_W-1:0] TAIL_FIX40 = 9'd40;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_start;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] name_char;
    logic              name_end;
    logic [WORD_W-1:0] file_offset;
    logic [WORD_W-1:0] stored_size;
    logic [WORD_W-1:0] full_size;
    logic [BYTE_W-1:0] entry_flag;
  } result_t;

  // Handshake between the input stage, the parser and the result register
  typedef struct packed {
    logic fire;    // input stage hands its word to the parser this cycle
    logic emit;    // parser produces a result for that word
  } step_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adrp_if.sv =====
// ----------------------------------------------------------------------------
// adrp_in_if / adrp_out_if
// Valid/ready channels for directory bytes and parsed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface adrp_in_if;
  import adrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface adrp_out_if;
  import adrp_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] name_char;
  logic              name_end;
  logic [WORD_W-1:0] file_offset;
  logic [WORD_W-1:0] stored_size;
  logic [WORD_W-1:0] full_size;
  logic [BYTE_W-1:0] entry_flag;

  modport source (
    output valid, output kind, output name_char, output name_end,
    output file_offset, output stored_size, output full_size, output entry_flag,
    input ready
  );
  modport sink (
    input valid, input kind, input name_char, input name_end,
    input file_offset, input stored_size, input full_size, input entry_flag,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/adrp_parser.sv =====
// ----------------------------------------------------------------------------
// adrp_parser
// Record phase tracker and field gatherer; one directory byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module adrp_parser #(
  parameter int unsigned HEADER_BYTES = adrp_pkg::HEADER_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire adrp_pkg::item_t   item_i,
  input  wire logic              fire_i,
  output logic                   emit_o,
  output adrp_pkg::result_t      result_o
);
  import adrp_pkg::*;

  typedef enum logic [2:0] {
    PhHeader  = 3'd0,
    PhNameLen = 3'd1,
    PhName    = 3'd2,
    PhFlag    = 3'd3,
    PhWords   = 3'd4,
    PhTailLen = 3'd5,
    PhSkip    = 3'd6
  } phase_e;

  localparam logic [LEFT_W-1:0] LeftRst  = LEFT_W'(HEADER_BYTES);
  localparam phase_e            PhaseRst = (HEADER_BYTES == 0) ? PhNameLen : PhHeader;

  phase_e             phase_q, phase_d, phase_c;
  logic [LEFT_W-1:0]  left_q, left_d, left_c, left_dec;
  logic [BYTE_W-1:0]  flag_q, flag_d, flag_c;
  logic [WORD_W-1:0]  off_q, off_d, off_c;
  logic [WORD_W-1:0]  pk_q, pk_d, pk_c;
  logic [WORD_W-1:0]  shift_q, shift_d, shift_c, shift_nxt;
  logic [BYTE_W-1:0]  b;

  assign b = item_i.data_byte;

  // Stream start restarts the parser; the same byte is the first header byte.
  always_comb begin
    if (item_i.stream_start) begin
      phase_c = PhaseRst;
      left_c  = LeftRst;
      flag_c  = '0;
      off_c   = '0;
      pk_c    = '0;
      shift_c = '0;
    end else begin
      phase_c = phase_q;
      left_c  = left_q;
      flag_c  = flag_q;
      off_c   = off_q;
      pk_c    = pk_q;
      shift_c = shift_q;
    end
  end

  assign left_dec  = left_c - LEFT_W'(1);
  assign shift_nxt = {b, shift_c[WORD_W-1:BYTE_W]};

  always_comb begin
    phase_d  = phase_c;
    left_d   = left_c;
    flag_d   = flag_c;
    off_d    = off_c;
    pk_d     = pk_c;
    shift_d  = shift_c;
    emit_o   = 1'b0;
    result_o = '0;
    case (phase_c)
      PhHeader: begin
        left_d = left_dec;
        if (left_dec == '0) phase_d = PhNameLen;
      end
      PhName: begin
        left_d             = left_dec;
        emit_o             = 1'b1;
        result_o.kind      = KIND_NAME;
        result_o.name_char = b;
        result_o.name_end  = (left_dec == '0);
        if (left_dec == '0) phase_d = PhFlag;
      end
      PhFlag: begin
        flag_d  = b;
        shift_d = '0;
        left_d  = WORD_BYTES;
        phase_d = PhWords;
      end
      PhWords: begin
        shift_d = shift_nxt;
        left_d  = left_dec;
        if (left_dec == OFFSET_DONE) begin
          off_d = shift_nxt;
        end else if (left_dec == PACKED_DONE) begin
          pk_d = shift_nxt;
        end else if (left_dec == '0) begin
          emit_o               = 1'b1;
          result_o.kind        = KIND_RECORD;
          result_o.file_offset = off_c;
          result_o.stored_size = pk_c;
          result_o.full_size   = shift_nxt;
          result_o.entry_flag  = flag_c;
          if (flag_c == FLAG_LEN16 || flag_c == FLAG_LEN20) begin
            phase_d = PhTailLen;
          end else if (flag_c == FLAG_FIX20) begin
            left_d  = TAIL_FIX20;
            phase_d = PhSkip;
          end else if (flag_c == FLAG_FIX40) begin
            left_d  = TAIL_FIX40;
            phase_d = PhSkip;
          end else begin
            phase_d = PhNameLen;
          end
        end
      end
      PhTailLen: begin
        left_d  = LEFT_W'(b) + ((flag_c == FLAG_LEN16) ? TAIL_EXTRA16 : TAIL_EXTRA20);
        phase_d = PhSkip;
      end
      PhSkip: begin
        left_d = left_dec;
        if (left_dec == '0) phase_d = PhNameLen;
      end
      default: begin
        // name length, and the unused code
        left_d  = LEFT_W'(b);
        phase_d = (b != '0) ? PhName : PhFlag;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseRst;
      left_q  <= LeftRst;
      flag_q  <= '0;
      off_q   <= '0;
      pk_q    <= '0;
      shift_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      flag_q  <= flag_d;
      off_q   <= off_d;
      pk_q    <= pk_d;
      shift_q <= shift_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adrp_out_stage.sv =====
// ----------------------------------------------------------------------------
// adrp_out_stage
// Result register that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module adrp_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire adrp_pkg::step_ctl_t ctl_i,
  input  wire adrp_pkg::result_t   result_i,
  output logic                     free_o,
  adrp_out_if.source               out_o
);
  import adrp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held word leaves this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) valid_d = 1'b0;
    if (ctl_i.fire && ctl_i.emit) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire && ctl_i.emit) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = res_q.kind;
  assign out_o.name_char   = res_q.name_char;
  assign out_o.name_end    = res_q.name_end;
  assign out_o.file_offset = res_q.file_offset;
  assign out_o.stored_size = res_q.stored_size;
  assign out_o.full_size   = res_q.full_size;
  assign out_o.entry_flag  = res_q.entry_flag;

endmodule

`default_nettype wire

// ===== hw/rtl/archive_directory_record_parser.sv =====
// ----------------------------------------------------------------------------
// archive_directory_record_parser
// Parses an inflated archive directory byte stream into name bytes and
// completed directory records.
// ----------------------------------------------------------------------------
//
//  channel  dir  words carry                                   accepted when
//  -------  ---  --------------------------------------------  ---------------
//  in_i     in   data_byte, stream_start                       valid && ready
//  out_o    out  kind, name_char, name_end, file_offset,       valid && ready
//                stored_size, full_size, entry_flag
//
//  One byte per cycle sustained while out_o.ready stays high: a byte waits in
//  the input register, is parsed by the phase logic, and any result lands in
//  the result register, which drives out_o.valid.
//  Reset: the parser comes up skipping HEADER_BYTES header bytes (or at the
//  name length byte when HEADER_BYTES is 0); both stage valids clear.
//  Stalls: a held result only blocks the input register while out_o.ready is
//  low; in_i.ready then falls once the input register is also occupied.
//  A stream_start byte restarts the parser and counts as the first header byte.
//
`default_nettype none

module archive_directory_record_parser #(
  parameter int unsigned HEADER_BYTES = adrp_pkg::HEADER_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  adrp_in_if.sink    in_i,
  adrp_out_if.source out_o
);
  import adrp_pkg::*;

  // Input register
  logic      in_valid_q;
  item_t     in_item_q;
  logic      out_free;
  step_ctl_t ctl;
  result_t   result;
  logic      emit;

  // Hand the held byte to the parser whenever the result register can take
  // its result; the held byte may produce nothing, but waiting is harmless.
  assign ctl.fire = in_valid_q && out_free;
  assign ctl.emit = emit;

  // Accept a new byte whenever the input register is empty or empties this cycle
  assign in_i.ready = !in_valid_q || ctl.fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Payload: hold while stalled, load on accept
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.data_byte    <= in_i.data_byte;
      in_item_q.stream_start <= in_i.stream_start;
    end
  end

  adrp_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item_q),
    .fire_i   (ctl.fire),
    .emit_o   (emit),
    .result_o (result)
  );

  adrp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/adrp_checker.sv =====
// ----------------------------------------------------------------------------
// adrp_checker
// Port-level checks for the directory record parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "archive_directory_record_parser_assert.svh"

module adrp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        kind_i,
  input wire logic [7:0]  name_char_i,
  input wire logic        name_end_i,
  input wire logic [31:0] file_offset_i,
  input wire logic [31:0] stored_size_i,
  input wire logic [31:0] full_size_i,
  input wire logic [7:0]  entry_flag_i
);
  import adrp_pkg::*;

  logic [7:0] rec_zero;
  logic       name_zero;

  assign name_zero = (name_char_i == '0) && !name_end_i;
  assign rec_zero  = {file_offset_i == '0, stored_size_i == '0,
                      full_size_i == '0, entry_flag_i == '0, 4'hF};

  `ADRP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(kind_i) && $stable(name_char_i) && $stable(full_size_i), "result word changed while stalled")
  `ADRP_ASSERT_SAME(a_rec_no_name, out_valid_i && kind_i == KIND_RECORD, name_zero, "record word carries name bits")
  `ADRP_ASSERT_SAME(a_name_no_rec, out_valid_i && kind_i == KIND_NAME, rec_zero == 8'hFF, "name word carries record fields")
  `ADRP_ASSERT_SAME(a_ready_when_empty, !out_valid_i, in_ready_i, "input stalled with empty result register")

endmodule

bind archive_directory_record_parser adrp_checker u_adrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .name_char_i   (out_o.name_char),
  .name_end_i    (out_o.name_end),
  .file_offset_i (out_o.file_offset),
  .stored_size_i (out_o.stored_size),
  .full_size_i   (out_o.full_size),
  .entry_flag_i  (out_o.entry_flag)
);

`default_nettype wire

// ===== bench/adrp_result_check.sv =====
// ----------------------------------------------------------------------------
// adrp_result_check
// Watches both channels of the directory record parser, parses every accepted
// directory byte on its own and compares each result word with its due value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adrp_result_check
  import adrp_pkg::*;
#(
  parameter int unsigned HDR_BYTES = HEADER_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  adrp_in_if   dir_in_i,
  adrp_out_if  dir_out_i,
  output int   fail_count_o,
  output int   owed_count_o,
  output int   names_o,
  output int   records_o
);

  typedef enum logic [2:0] {
    SKIP_HDR, GET_NLEN, GET_NAME, GET_FLAG, GET_WORDS, GET_TLEN, SKIP_TAIL, SPARE
  } dir_phase_e;

  dir_phase_e        phase;
  logic [LEFT_W-1:0] left;
  logic [BYTE_W-1:0] flag;
  logic [WORD_W-1:0] offset_acc;
  logic [WORD_W-1:0] packed_acc;
  logic [WORD_W-1:0] shreg;

  result_t owed_results[$];

  function automatic void restart_parse();
    left       = LEFT_W'(HDR_BYTES);
    phase      = (left != '0) ? SKIP_HDR : GET_NLEN;
    flag       = '0;
    offset_acc = '0;
    packed_acc = '0;
    shreg      = '0;
  endfunction

  // Advance the parse by one directory byte; hit marks a result word.
  function automatic void parse_dir_byte(input logic [BYTE_W-1:0] b, input logic start,
                                         output logic hit, output result_t r);
    r   = '0;
    hit = 1'b0;
    if (start) restart_parse();
    case (phase)
      SKIP_HDR: begin
        left = left - LEFT_W'(1);
        if (left == '0) phase = GET_NLEN;
      end
      GET_NAME: begin
        left        = left - LEFT_W'(1);
        r.kind      = KIND_NAME;
        r.name_char = b;
        r.name_end  = (left == '0);
        hit         = 1'b1;
        if (left == '0) phase = GET_FLAG;
      end
      GET_FLAG: begin
        flag  = b;
        shreg = '0;
        left  = WORD_BYTES;
        phase = GET_WORDS;
      end
      GET_WORDS: begin
        shreg = {b, shreg[WORD_W-1:BYTE_W]};
        left  = left - LEFT_W'(1);
        if (left == OFFSET_DONE) begin
          offset_acc = shreg;
        end else if (left == PACKED_DONE) begin
          packed_acc = shreg;
        end else if (left == '0) begin
          r.kind        = KIND_RECORD;
          r.file_offset = offset_acc;
          r.stored_size = packed_acc;
          r.full_size   = shreg;
          r.entry_flag  = flag;
          hit           = 1'b1;
          if (flag == FLAG_LEN16 || flag == FLAG_LEN20) begin
            phase = GET_TLEN;
          end else if (flag == FLAG_FIX20) begin
            left  = TAIL_FIX20;
            phase = SKIP_TAIL;
          end else if (flag == FLAG_FIX40) begin
            left  = TAIL_FIX40;
            phase = SKIP_TAIL;
          end else begin
            phase = GET_NLEN;
          end
        end
      end
      GET_TLEN: begin
        left  = {1'b0, b} + ((flag == FLAG_LEN16) ? TAIL_EXTRA16 : TAIL_EXTRA20);
        phase = SKIP_TAIL;
      end
      SKIP_TAIL: begin
        left = left - LEFT_W'(1);
        if (left == '0) phase = GET_NLEN;
      end
      default: begin
        // name length byte, and the spare code behaves the same
        left  = {1'b0, b};
        phase = (b != '0) ? GET_NAME : GET_FLAG;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    result_t fresh;
    logic    hit;
    logic    bad;
    if (!rst_ni) begin
      restart_parse();
      owed_results.delete();
      owed_count_o = 0;
    end else begin
      // check first: a result word never belongs to a byte of the same edge
      if (dir_out_i.valid && dir_out_i.ready) begin
        got = '{dir_out_i.kind, dir_out_i.name_char, dir_out_i.name_end,
                dir_out_i.file_offset, dir_out_i.stored_size, dir_out_i.full_size,
                dir_out_i.entry_flag};
        if (owed_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result word with nothing due: %p", $realtime, got);
          fail_count_o++;
        end else begin
          want = owed_results.pop_front();
          bad  = (got.kind        !== want.kind)        ||
                 (got.name_char   !== want.name_char)   ||
                 (got.name_end    !== want.name_end)    ||
                 (got.file_offset !== want.file_offset) ||
                 (got.stored_size !== want.stored_size) ||
                 (got.full_size   !== want.full_size)   ||
                 (got.entry_flag  !== want.entry_flag);
          if (bad) begin
            if (fail_count_o < 10)
              $display("%0t: result mismatch\n  due: %p\n  got: %p", $realtime, want, got);
            fail_count_o++;
          end else if (want.kind == KIND_NAME) begin
            names_o++;
          end else begin
            records_o++;
          end
        end
      end
      if (dir_in_i.valid && dir_in_i.ready) begin
        parse_dir_byte(dir_in_i.data_byte, dir_in_i.stream_start, hit, fresh);
        if (hit) owed_results.push_back(fresh);
      end
      owed_count_o = owed_results.size();
    end
  end

  initial begin
    fail_count_o = 0;
    owed_count_o = 0;
    names_o      = 0;
    records_o    = 0;
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Feeds the directory record parser whole directories, cut-short directories
// and junk, with random gaps on the byte side and random stalls on the result
// side, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import adrp_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RAND_BYTES = 1050;

  logic clk_i = 1'b0;
  logic rst_ni;

  adrp_in_if  dir_in ();
  adrp_out_if dir_out ();

  int fail_count;
  int owed_count;
  int names_seen;
  int records_seen;

  // Byte stream bookkeeping
  int  sent_bytes;
  int  dir_count;
  int  cut_count;
  int  cut_left;      // bytes left before a directory is cut short, -1 = never
  bit  in_quiet;      // stretch with no gaps on the byte side
  bit  out_quiet;     // stretch with no stalls on the result side

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  archive_directory_record_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (dir_in),
    .out_o  (dir_out)
  );

  adrp_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_in_i     (dir_in),
    .dir_out_i    (dir_out),
    .fail_count_o (fail_count),
    .owed_count_o (owed_count),
    .names_o      (names_seen),
    .records_o    (records_seen)
  );

  // Draw an idle count from 0 to 9; now and then flip into or out of a
  // stretch with no idling at all.
  function automatic int idle_draw(ref bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Offer one directory byte and hold it until the parser takes it. With no
  // gap, valid stays high and only the payload moves on at the accept edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    int gap;
    if (cut_left == 0) return;   // drop the rest of a cut-short directory
    if (cut_left > 0) cut_left--;
    gap = idle_draw(in_quiet);
    if (gap > 0) begin
      dir_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dir_in.valid        <= 1'b1;
    dir_in.data_byte    <= b;
    dir_in.stream_start <= start;
    do @(posedge clk_i); while (!dir_in.ready);
    sent_bytes++;
  endtask

  // Send a little-endian 32-bit field, biased toward all-zero and all-one.
  task automatic send_field();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      default: w = $urandom;
    endcase
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 1'b0);
  endtask

  // One well-formed record with random content.
  task automatic send_record();
    int                nlen;
    int                tlen;
    int                pick;
    logic [BYTE_W-1:0] fl;
    pick = $urandom_range(0, 99);
    if (pick < 15)      nlen = 0;
    else if (pick < 80) nlen = $urandom_range(1, 6);
    else if (pick < 97) nlen = $urandom_range(7, 40);
    else                nlen = $urandom_range(200, 255);
    send_byte(BYTE_W'(nlen), 1'b0);
    repeat (nlen) send_byte(BYTE_W'($urandom), 1'b0);

    case ($urandom_range(0, 6))
      0:       fl = FLAG_LEN16;
      1:       fl = FLAG_FIX20;
      2:       fl = FLAG_FIX40;
      3:       fl = FLAG_LEN20;
      default: fl = BYTE_W'($urandom);   // mostly a flag with no tail
    endcase
    send_byte(fl, 1'b0);
    repeat (3) send_field();

    // Tail: skipped by the parser, so its content is free
    if (fl == FLAG_LEN16 || fl == FLAG_LEN20) begin
      tlen = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 255);
      send_byte(BYTE_W'(tlen), 1'b0);
      tlen += (fl == FLAG_LEN16) ? int'(TAIL_EXTRA16) : int'(TAIL_EXTRA20);
      repeat (tlen) send_byte(BYTE_W'($urandom), 1'b0);
    end else if (fl == FLAG_FIX20) begin
      repeat (int'(TAIL_FIX20)) send_byte(BYTE_W'($urandom), 1'b0);
    end else if (fl == FLAG_FIX40) begin
      repeat (int'(TAIL_FIX40)) send_byte(BYTE_W'($urandom), 1'b0);
    end
  endtask

  // A directory opens with a stream_start byte and the header. Most carry
  // a run of records; some are cut short anywhere and some carry only junk,
  // where stray stream_start bytes restart the parser mid-stream.
  task automatic send_directory();
    dir_count++;
    if ($urandom_range(0, 5) == 0) begin
      cut_left = $urandom_range(1, 80);
      cut_count++;
    end
    send_byte(BYTE_W'($urandom), 1'b1);
    repeat (HEADER_BYTES_DEF - 1) send_byte(BYTE_W'($urandom), 1'b0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(5, 40))
        send_byte(BYTE_W'($urandom), $urandom_range(0, 15) == 0);
    end else begin
      repeat ($urandom_range(1, 6)) send_record();
    end
    cut_left = -1;
  endtask

  // Result side: stall a random number of cycles before each result word,
  // then hold ready high until one is taken.
  initial begin
    int stall;
    dir_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_draw(out_quiet);
      if (stall > 0) begin
        dir_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      dir_out.ready <= 1'b1;
      do @(posedge clk_i); while (!dir_out.valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int directed_bytes;
    sent_bytes          = 0;
    dir_count           = 0;
    cut_count           = 0;
    cut_left            = -1;
    in_quiet            = 1'b0;
    out_quiet           = 1'b0;
    rst_ni              <= 1'b0;
    dir_in.valid        <= 1'b0;
    dir_in.data_byte    <= '0;
    dir_in.stream_start <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stream start on the first header byte, header bytes at the
    // extremes, then a record with an empty name, a flag with no tail and
    // fields at all-one, all-zero and top-and-bottom-bit values.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (HEADER_BYTES_DEF - 4) send_byte(BYTE_W'($urandom), 1'b0);
    send_byte(8'h00, 1'b0);                  // empty name
    send_byte(8'h00, 1'b0);                  // flag with no tail
    repeat (4) send_byte(8'hFF, 1'b0);       // data offset
    repeat (4) send_byte(8'h00, 1'b0);       // packed size
    send_byte(8'h01, 1'b0);                  // unpacked size 0x8000_0001
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    directed_bytes = sent_bytes;

    while (sent_bytes - directed_bytes < RAND_BYTES) send_directory();
    dir_in.valid <= 1'b0;

    // Drain: wait for every due result word, then let the pipeline settle.
    while (owed_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d directory bytes in %0d directories (%0d cut short).",
             sent_bytes, dir_count + 1, cut_count);
    $display("Matched %0d name bytes and %0d records; %0d mismatches.",
             names_seen, records_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5ms;
    $display("Timeout waiting for the parser to finish");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== archive_directory_record_parser.f =====
+incdir+hw/rtl
hw/rtl/adrp_pkg.sv
hw/rtl/adrp_if.sv
hw/rtl/adrp_parser.sv
hw/rtl/adrp_out_stage.sv
hw/rtl/archive_directory_record_parser.sv
hw/rtl/adrp_checker.sv
bench/adrp_result_check.sv
bench/tb.sv
